FILE: src/wpsp_pkg.sv
// ============================================================================
// wpsp_pkg
// Shared types and constants for the world point to screen projection block.
// ============================================================================
package wpsp_pkg;

   localparam int MaxScreen  = 16384;
   localparam int FracBits   = 24;
   localparam int OutW       = 23;
   localparam int SizeW      = 15;
   localparam int CoordW     = 32;
   localparam int ClipW      = 52;  // three Q.16 products (48 bits each) plus constant
   localparam int NumW       = ClipW + 1;
   localparam int AddrW      = 6;
   localparam int DivSteps   = 3;   // quotient bits resolved per divider stage
   localparam int DivStages  = 8;   // 24 quotient bits

   typedef enum logic [2:0] {
      REG_COEF_X_AB  = 3'd0,
      REG_COEF_X_CD  = 3'd1,
      REG_COEF_Y_AB  = 3'd2,
      REG_COEF_Y_CD  = 3'd3,
      REG_COEF_W_AB  = 3'd4,
      REG_COEF_W_CD  = 3'd5,
      REG_SCREEN_W   = 3'd6,
      REG_SCREEN_H   = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [63:0] x_ab;
      logic [63:0] x_cd;
      logic [63:0] y_ab;
      logic [63:0] y_cd;
      logic [63:0] w_ab;
      logic [63:0] w_cd;
      logic [SizeW-1:0] width;
      logic [SizeW-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic signed [CoordW-1:0] x;
      logic signed [CoordW-1:0] y;
      logic signed [CoordW-1:0] z;
   } point_type;

   typedef struct packed {
      logic             visible;
      logic [OutW-1:0]  sx;
      logic [OutW-1:0]  sy;
   } result_type;

   // floor of a Q32.32 product to Q.16, sign extended to clip width
   function automatic logic signed [ClipW-1:0] floor_q16(input logic signed [63:0] p);
      logic signed [47:0] t;
      t = p[63:16];
      return ClipW'(t);
   endfunction

endpackage

FILE: src/wpsp_stream_if.sv
// ============================================================================
// wpsp_stream_if
// Valid/ready stream channel carrying a request or a result.
// ============================================================================
interface wpsp_stream_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: src/world_point_screen_projection.sv
// ============================================================================
// world_point_screen_projection
// Projects a Q16.16 world point through three matrix rows into pixel space.
// ============================================================================
// channel   dir  ports    payload
// request   in   req_     point_x, point_y, point_z (signed Q16.16)
// result    out  rsp_     visible, screen_x, screen_y (unsigned Q.8)
// config    in   csr_     APB, 64-bit data, registers at 8*i
//
// one request per cycle while the result side does not stall; stages: product, sum, clip test,
// eight divider slices of three quotient bits, scale multiply, result
// reset clears the pipe valid bits and the configuration registers to zero
// a stall on the result side holds every stage; the front takes requests
// while the last stage is empty or draining
module world_point_screen_projection (
   input  logic                       clock,
   input  logic                       reset,
   wpsp_stream_if.sink                req,
   wpsp_stream_if.source              rsp,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [wpsp_pkg::AddrW-1:0] csr_paddr,
   input  logic [63:0]                csr_pwdata,
   output logic [63:0]                csr_prdata,
   output logic                       csr_pready
);
   localparam int CW = wpsp_pkg::ClipW;
   localparam int NW = wpsp_pkg::NumW;
   localparam int QW = wpsp_pkg::FracBits + 1;
   localparam int DS = wpsp_pkg::DivStages;
   localparam int NV = 5 + DS;  // valid bits along the pipe

   wpsp_pkg::cfg_type cfg;
   wpsp_pkg::point_type pt;
   logic adv;
   logic [NV-1:0] vld_ff, vld_in;

   wpsp_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .cfg
   );

   assign pt  = req.data;
   assign adv = !vld_ff[NV-1] || rsp.ready;
   assign req.ready = adv;

   // valid bits shift with the pipe
   assign vld_in = {vld_ff[NV-2:0], req.valid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: nine products floored to Q.16
   logic signed [CW-1:0] p_ff [9];
   logic signed [CW-1:0] k_ff [3];
   logic [63:0] ab [3];
   logic [63:0] cd [3];
   assign ab[0] = cfg.x_ab; assign cd[0] = cfg.x_cd;
   assign ab[1] = cfg.y_ab; assign cd[1] = cfg.y_cd;
   assign ab[2] = cfg.w_ab; assign cd[2] = cfg.w_cd;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            p_ff[3*r]   <= wpsp_pkg::floor_q16($signed(ab[r][63:32]) * pt.x);
            p_ff[3*r+1] <= wpsp_pkg::floor_q16($signed(ab[r][31:0]) * pt.y);
            p_ff[3*r+2] <= wpsp_pkg::floor_q16($signed(cd[r][63:32]) * pt.z);
            k_ff[r]     <= CW'($signed(cd[r][31:0]));
         end
      end
   end

   // stage 2: row sums
   logic signed [CW-1:0] clip_ff [3];
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            clip_ff[r] <= p_ff[3*r] + p_ff[3*r+1] + p_ff[3*r+2] + k_ff[r];
         end
      end
   end

   // stage 3: clip test and divider operands
   logic signed [CW-1:0] cx, cy, cw;
   logic vis_in;
   logic [NW-1:0] nx_in, ny_in, den_in;
   assign cx = clip_ff[0];
   assign cy = clip_ff[1];
   assign cw = clip_ff[2];
   always_comb begin
      vis_in = (cfg.width != '0) && (cfg.height != '0) && (cw > 0)
               && (cx >= -cw) && (cx <= cw) && (cy >= -cw) && (cy <= cw);
      nx_in  = NW'(cx + cw);
      ny_in  = NW'(cw - cy);
      den_in = {cw[CW-1:0], 1'b0};
   end

   logic vis_ff [DS+1];
   logic [NW-1:0] den_ff [DS+1];
   logic [NW-1:0] rx_s [DS+1];
   logic [NW-1:0] ry_s [DS+1];
   logic [QW-1:0] qx_s [DS+1];
   logic [QW-1:0] qy_s [DS+1];
   logic [NW-1:0] nx_ff, ny_ff;
   logic fx_ff, fy_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         vis_ff[0] <= vis_in;
         den_ff[0] <= den_in;
         nx_ff     <= nx_in;
         ny_ff     <= ny_in;
         fx_ff     <= nx_in >= den_in;
         fy_ff     <= ny_in >= den_in;
      end
   end
   // a full ratio skips the divide: remainder zeroed, forced at the end
   assign rx_s[0] = fx_ff ? '0 : nx_ff;
   assign ry_s[0] = fy_ff ? '0 : ny_ff;
   assign qx_s[0] = '0;
   assign qy_s[0] = '0;

   logic fx_d [DS+1];
   logic fy_d [DS+1];
   assign fx_d[0] = fx_ff;
   assign fy_d[0] = fy_ff;

   // divider slices
   for (genvar s = 0; s < DS; s++) begin : g_div
      wpsp_div_stage u_div (
         .clock, .enable(adv),
         .rem_x_i(rx_s[s]), .rem_y_i(ry_s[s]), .den_i(den_ff[s]),
         .q_x_i(qx_s[s]), .q_y_i(qy_s[s]),
         .rem_x_o(rx_s[s+1]), .rem_y_o(ry_s[s+1]),
         .q_x_o(qx_s[s+1]), .q_y_o(qy_s[s+1])
      );
      always_ff @(posedge clock) begin
         if (adv) begin
            vis_ff[s+1] <= vis_ff[s];
            den_ff[s+1] <= den_ff[s];
            fx_d[s+1]   <= fx_d[s];
            fy_d[s+1]   <= fy_d[s];
         end
      end
   end

   // 24 quotient bits came out, the fraction is the quotient itself
   logic [QW-1:0] frx, fry;
   assign frx = fx_d[DS] ? QW'(1 << wpsp_pkg::FracBits) : qx_s[DS];
   assign fry = fy_d[DS] ? QW'(1 << wpsp_pkg::FracBits) : qy_s[DS];

   // scale multiply
   logic [wpsp_pkg::SizeW-1:0] szw, szh;
   assign szw = (cfg.width  > wpsp_pkg::SizeW'(wpsp_pkg::MaxScreen))
                ? wpsp_pkg::SizeW'(wpsp_pkg::MaxScreen) : cfg.width;
   assign szh = (cfg.height > wpsp_pkg::SizeW'(wpsp_pkg::MaxScreen))
                ? wpsp_pkg::SizeW'(wpsp_pkg::MaxScreen) : cfg.height;
   logic [QW+wpsp_pkg::SizeW-1:0] mx_ff, my_ff;
   logic vm_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         mx_ff <= frx * szw;
         my_ff <= fry * szh;
         vm_ff <= vis_ff[DS];
      end
   end

   // final result register with saturation
   localparam int MW = QW + wpsp_pkg::SizeW - 16;
   logic [MW-1:0] sx_w, sy_w;
   wpsp_pkg::result_type res_ff;
   assign sx_w = mx_ff[QW+wpsp_pkg::SizeW-1:16];
   assign sy_w = my_ff[QW+wpsp_pkg::SizeW-1:16];
   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff.visible <= vm_ff;
         res_ff.sx <= !vm_ff ? '0 : (sx_w > MW'({wpsp_pkg::OutW{1'b1}}))
                      ? {wpsp_pkg::OutW{1'b1}} : sx_w[wpsp_pkg::OutW-1:0];
         res_ff.sy <= !vm_ff ? '0 : (sy_w > MW'({wpsp_pkg::OutW{1'b1}}))
                      ? {wpsp_pkg::OutW{1'b1}} : sy_w[wpsp_pkg::OutW-1:0];
      end
   end

   assign rsp.valid = vld_ff[NV-1];
   assign rsp.data  = res_ff;
endmodule

FILE: src/wpsp_csr.sv
// ============================================================================
// wpsp_csr
// APB-style register file holding the matrix rows and the screen size.
// ============================================================================
module wpsp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [wpsp_pkg::AddrW-1:0]  csr_paddr,
   input  logic [63:0]                 csr_pwdata,
   output logic [63:0]                 csr_prdata,
   output logic                        csr_pready,
   output wpsp_pkg::cfg_type           cfg
);
   wpsp_pkg::cfg_type cfg_ff, cfg_in;
   wpsp_pkg::reg_index_type idx;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign idx   = wpsp_pkg::reg_index_type'(csr_paddr[5:3]);
   assign wr_en = csr_psel & csr_penable & csr_pwrite & (csr_paddr[2:0] == 3'd0);

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            wpsp_pkg::REG_COEF_X_AB: cfg_in.x_ab   = csr_pwdata;
            wpsp_pkg::REG_COEF_X_CD: cfg_in.x_cd   = csr_pwdata;
            wpsp_pkg::REG_COEF_Y_AB: cfg_in.y_ab   = csr_pwdata;
            wpsp_pkg::REG_COEF_Y_CD: cfg_in.y_cd   = csr_pwdata;
            wpsp_pkg::REG_COEF_W_AB: cfg_in.w_ab   = csr_pwdata;
            wpsp_pkg::REG_COEF_W_CD: cfg_in.w_cd   = csr_pwdata;
            wpsp_pkg::REG_SCREEN_W:  cfg_in.width  = csr_pwdata[wpsp_pkg::SizeW-1:0];
            wpsp_pkg::REG_SCREEN_H:  cfg_in.height = csr_pwdata[wpsp_pkg::SizeW-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // register read mux
   always_comb begin
      case (idx)
         wpsp_pkg::REG_COEF_X_AB: csr_prdata = cfg_ff.x_ab;
         wpsp_pkg::REG_COEF_X_CD: csr_prdata = cfg_ff.x_cd;
         wpsp_pkg::REG_COEF_Y_AB: csr_prdata = cfg_ff.y_ab;
         wpsp_pkg::REG_COEF_Y_CD: csr_prdata = cfg_ff.y_cd;
         wpsp_pkg::REG_COEF_W_AB: csr_prdata = cfg_ff.w_ab;
         wpsp_pkg::REG_COEF_W_CD: csr_prdata = cfg_ff.w_cd;
         wpsp_pkg::REG_SCREEN_W:  csr_prdata = 64'(cfg_ff.width);
         wpsp_pkg::REG_SCREEN_H:  csr_prdata = 64'(cfg_ff.height);
         default: csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;
endmodule

FILE: src/wpsp_div_stage.sv
// ============================================================================
// wpsp_div_stage
// One registered slice of the restoring divider: three quotient bits.
// ============================================================================
module wpsp_div_stage (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [wpsp_pkg::NumW-1:0]     rem_x_i,
   input  logic [wpsp_pkg::NumW-1:0]     rem_y_i,
   input  logic [wpsp_pkg::NumW-1:0]     den_i,
   input  logic [wpsp_pkg::FracBits:0]   q_x_i,
   input  logic [wpsp_pkg::FracBits:0]   q_y_i,
   output logic [wpsp_pkg::NumW-1:0]     rem_x_o,
   output logic [wpsp_pkg::NumW-1:0]     rem_y_o,
   output logic [wpsp_pkg::FracBits:0]   q_x_o,
   output logic [wpsp_pkg::FracBits:0]   q_y_o
);
   localparam int NW = wpsp_pkg::NumW;
   localparam int QW = wpsp_pkg::FracBits + 1;

   logic [NW-1:0] rx_in, ry_in;
   logic [QW-1:0] qx_in, qy_in;
   logic [NW-1:0] rx_ff, ry_ff;
   logic [QW-1:0] qx_ff, qy_ff;

   // shift-compare-subtract steps, remainder stays below the divisor
   always_comb begin
      logic [NW:0] tx, ty;
      rx_in = rem_x_i;
      ry_in = rem_y_i;
      qx_in = q_x_i;
      qy_in = q_y_i;
      for (int i = 0; i < wpsp_pkg::DivSteps; i++) begin
         tx = {rx_in, 1'b0};
         ty = {ry_in, 1'b0};
         qx_in = {qx_in[QW-2:0], 1'b0};
         qy_in = {qy_in[QW-2:0], 1'b0};
         if (tx >= {1'b0, den_i}) begin
            tx = tx - {1'b0, den_i};
            qx_in[0] = 1'b1;
         end
         if (ty >= {1'b0, den_i}) begin
            ty = ty - {1'b0, den_i};
            qy_in[0] = 1'b1;
         end
         rx_in = tx[NW-1:0];
         ry_in = ty[NW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         qx_ff <= qx_in;
         qy_ff <= qy_in;
      end
   end

   assign rem_x_o = rx_ff;
   assign rem_y_o = ry_ff;
   assign q_x_o   = qx_ff;
   assign q_y_o   = qy_ff;
endmodule
